### design/quaternion_product_rotate_top_macros.svh
// Assertion macros shared by the quaternion product / rotate design.
`ifndef QUATERNION_PRODUCT_ROTATE_TOP_MACROS_SVH
`define QUATERNION_PRODUCT_ROTATE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define QPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define QPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/qpr_pkg.sv
// Types, widths and arithmetic helpers for the quaternion product / rotate pipeline.
package qpr_pkg;

  localparam int unsigned COMP_W = 16;
  localparam int unsigned FRAC_W = 14;
  localparam int unsigned T_W    = 19;              // rounded first-pass rotation term
  localparam int unsigned CONJ_W = COMP_W + 1;      // negated rotor component
  localparam int unsigned PROD_W = T_W + CONJ_W;    // widest single product
  localparam int unsigned SUM_W  = PROD_W + 2;      // four-term sum
  localparam int unsigned RND_W  = SUM_W - FRAC_W;  // after rounding shift

  localparam logic signed [COMP_W-1:0] COMP_MAX = 16'sh7fff;
  localparam logic signed [COMP_W-1:0] COMP_MIN = 16'sh8000;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [RND_W-1:0]  rnd_t;

  typedef prod_t prod_arr_t [16];
  typedef sum_t  sum_arr_t  [4];

  typedef struct packed {
    logic  flag;
    comp_t val;
  } clip_t;

  // Hamilton product sums, p[4*j+k] = l[j] * r[k], components w,x,y,z
  function automatic sum_arr_t hamilton_sum(input prod_arr_t p);
    sum_arr_t o;
    o[0] = SUM_W'(p[0])  - SUM_W'(p[5])  - SUM_W'(p[10]) - SUM_W'(p[15]);
    o[1] = SUM_W'(p[1])  + SUM_W'(p[4])  + SUM_W'(p[11]) - SUM_W'(p[14]);
    o[2] = SUM_W'(p[2])  + SUM_W'(p[8])  + SUM_W'(p[13]) - SUM_W'(p[7]);
    o[3] = SUM_W'(p[3])  + SUM_W'(p[12]) + SUM_W'(p[6])  - SUM_W'(p[9]);
    return o;
  endfunction

  // Round Q10.28 to Q10.14, halves toward plus infinity
  function automatic rnd_t round_q(input sum_t s);
    sum_t tmp;
    tmp = s + SUM_W'(signed'(1 << (FRAC_W - 1)));
    return tmp[SUM_W-1:FRAC_W];
  endfunction

  // Saturate to the 16-bit component range
  function automatic clip_t clip16(input rnd_t v);
    clip_t c;
    if (v > RND_W'(COMP_MAX)) begin
      c.flag = 1'b1;
      c.val  = COMP_MAX;
    end else if (v < RND_W'(COMP_MIN)) begin
      c.flag = 1'b1;
      c.val  = COMP_MIN;
    end else begin
      c.flag = 1'b0;
      c.val  = v[COMP_W-1:0];
    end
    return c;
  endfunction

endpackage

### design/qpr_in_if.sv
// Request channel carrying the opcode and two quaternion operands.
interface qpr_in_if;
  import qpr_pkg::*;

  logic  valid;
  logic  ready;
  logic  op;
  comp_t a_w;
  comp_t a_x;
  comp_t a_y;
  comp_t a_z;
  comp_t b_w;
  comp_t b_x;
  comp_t b_y;
  comp_t b_z;

  modport source (output valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, input ready);
  modport sink   (input valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, output ready);
endinterface

### design/qpr_out_if.sv
// Result channel carrying the saturated quaternion and the clip flag.
interface qpr_out_if;
  import qpr_pkg::*;

  logic  valid;
  logic  ready;
  comp_t r_w;
  comp_t r_x;
  comp_t r_y;
  comp_t r_z;
  logic  saturated;

  modport source (output valid, r_w, r_x, r_y, r_z, saturated, input ready);
  modport sink   (input valid, r_w, r_x, r_y, r_z, saturated, output ready);
endinterface

### design/quaternion_product_rotate_top.sv
// Quaternion Hamilton product and vector rotation, Q2.14, five-stage pipeline.
//
// Five register stages: input capture, 16 multiplies, sum/round (product
// result or first rotation pass), 16 multiplies against conj(a), sum/round/
// saturate. A request passes from the capture register through each stage in
// turn to the output register; one request is accepted every clock unless
// back-pressure stalls the pipeline. Each stage only holds when it is full and
// the stage after it cannot take its contents, so bubbles close up under
// back-pressure. The stage count comes from the two banks of sixteen 16x16 /
// 19x17 multipliers, each followed by a register, with a sum/round stage after
// each bank.
module quaternion_product_rotate_top (
  input  logic clk_i,
  input  logic rst_ni,
  qpr_in_if.sink    in_i,
  qpr_out_if.source out_o
);
  import qpr_pkg::*;

  // stage enables, back to front
  logic en1, en2, en3, en4, en5;

  // stage 1: captured operands
  logic  v1_q, op1_q;
  comp_t a1_q [4];
  comp_t b1_q [4];

  // stage 2: first products
  logic                     v2_q, op2_q;
  comp_t                    a2_q [4];
  logic signed [2*COMP_W-1:0] p1_d [16];
  logic signed [2*COMP_W-1:0] p1_q [16];

  // stage 3: product result or rotation intermediate
  logic                      v3_q, op3_q;
  comp_t                     r3_d [4];
  comp_t                     r3_q [4];
  logic                      sat3_d, sat3_q;
  logic signed [T_W-1:0]     t3_d [4];
  logic signed [T_W-1:0]     t3_q [4];
  logic signed [CONJ_W-1:0]  c3_d [4];
  logic signed [CONJ_W-1:0]  c3_q [4];
  prod_arr_t                 pe1;
  sum_arr_t                  s1;

  // stage 4: second products
  logic      v4_q, op4_q;
  comp_t     r4_q [4];
  logic      sat4_q;
  prod_arr_t p2_d;
  prod_arr_t p2_q;

  // stage 5: output
  logic     v5_q, op5_q;
  comp_t    r5_d [4];
  comp_t    r5_q [4];
  logic     sat5_d, sat5_q;
  sum_arr_t s2;

  assign en5 = !v5_q || out_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1 capture; scalar of the vector is zero for rotation
  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q   <= in_i.op;
      a1_q[0] <= in_i.a_w;
      a1_q[1] <= in_i.a_x;
      a1_q[2] <= in_i.a_y;
      a1_q[3] <= in_i.a_z;
      b1_q[0] <= in_i.op ? '0 : in_i.b_w;
      b1_q[1] <= in_i.b_x;
      b1_q[2] <= in_i.b_y;
      b1_q[3] <= in_i.b_z;
    end
  end

  // first multiplier bank
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        p1_d[4*j+k] = a1_q[j] * b1_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      op2_q <= op1_q;
      a2_q  <= a1_q;
      p1_q  <= p1_d;
    end
  end

  // first sum and round; saturate for product, keep 19 bits for rotation
  always_comb begin
    clip_t cl;
    rnd_t  rd;
    sat3_d = 1'b0;
    for (int i = 0; i < 16; i++) begin
      pe1[i] = PROD_W'(p1_q[i]);
    end
    s1 = hamilton_sum(pe1);
    for (int i = 0; i < 4; i++) begin
      rd      = round_q(s1[i]);
      cl      = clip16(rd);
      r3_d[i] = cl.val;
      sat3_d  = sat3_d | cl.flag;
      t3_d[i] = rd[T_W-1:0];
    end
    c3_d[0] = CONJ_W'(a2_q[0]);
    for (int i = 1; i < 4; i++) begin
      c3_d[i] = -CONJ_W'(a2_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      op3_q  <= op2_q;
      r3_q   <= r3_d;
      sat3_q <= sat3_d;
      t3_q   <= t3_d;
      c3_q   <= c3_d;
    end
  end

  // second multiplier bank: t * conj(a)
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        p2_d[4*j+k] = t3_q[j] * c3_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      op4_q  <= op3_q;
      r4_q   <= r3_q;
      sat4_q <= sat3_q;
      p2_q   <= p2_d;
    end
  end

  // second sum, round and saturate; product requests pass through
  always_comb begin
    clip_t cl;
    cl = '0;
    s2 = hamilton_sum(p2_q);
    if (op4_q) begin
      r5_d[0] = '0;
      sat5_d  = 1'b0;
      for (int i = 1; i < 4; i++) begin
        cl      = clip16(round_q(s2[i]));
        r5_d[i] = cl.val;
        sat5_d  = sat5_d | cl.flag;
      end
    end else begin
      r5_d   = r4_q;
      sat5_d = sat4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      op5_q  <= op4_q;
      r5_q   <= r5_d;
      sat5_q <= sat5_d;
    end
  end

  assign out_o.valid     = v5_q;
  assign out_o.r_w       = r5_q[0];
  assign out_o.r_x       = r5_q[1];
  assign out_o.r_y       = r5_q[2];
  assign out_o.r_z       = r5_q[3];
  assign out_o.saturated = sat5_q;

`include "quaternion_product_rotate_top_macros.svh"

  `QPR_ASSERT_NOW(a_rot_w_zero, v5_q && op5_q, r5_q[0] == '0, "rotation result has nonzero r_w")
  `QPR_ASSERT_NOW(a_sat_at_limit, v5_q && sat5_q, r5_q[0] == COMP_MAX || r5_q[0] == COMP_MIN || r5_q[1] == COMP_MAX || r5_q[1] == COMP_MIN || r5_q[2] == COMP_MAX || r5_q[2] == COMP_MIN || r5_q[3] == COMP_MAX || r5_q[3] == COMP_MIN, "saturated set with no component at a limit")
  `QPR_ASSERT_NEXT(a_stage3_hold, v3_q && !en4, v3_q, "stalled stage 3 request lost")

endmodule
